// ===== sv/alsd_pkg.sv =====
// Shared types and constants for the APER length-stream deframer.
// No dependencies; every other file of the block uses this package.
package alsd_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MAX_MESSAGE_BYTES = 1'b0;

  localparam int MAX_MSG_W = 16;
  localparam logic [MAX_MSG_W-1:0] MAX_MSG_RESET = 16'hFFFF;

  // Body octets still to come: a fragment carries at most 4 * 16384 octets.
  localparam int REM_W = 17;
  localparam int FRAG_SHIFT = 14;
  localparam logic [5:0] MAX_FRAG_MULT = 6'd4;

  // Determinant octet classes.
  localparam logic [7:0] DET_CLASS_MASK = 8'hC0;
  localparam logic [7:0] DET_LONG_TAG = 8'h80;
  localparam logic [7:0] DET_VALUE_MASK = 8'h3F;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_DET  = 2'd1,
    ERR_OVERSIZE = 2'd2
  } framing_err_t;

  typedef struct packed {
    logic [7:0]   byte_out;
    logic         message_start;
    logic         message_end;
    framing_err_t framing_error;
  } result_t;

endpackage

// ===== sv/alsd_if.sv =====
// Stream channel interfaces for the deframer: octets in, marked octets out.
// Depends on alsd_pkg for the error code type.
interface alsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface alsd_out_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            byte_out;
  logic                  message_start;
  logic                  message_end;
  alsd_pkg::framing_err_t framing_error;

  modport source (output valid, output byte_out, output message_start,
                  output message_end, output framing_error, input ready);
  modport sink (input valid, input byte_out, input message_start,
                input message_end, input framing_error, output ready);
endinterface

// ===== sv/alsd_cfg_regs.sv =====
// APB-style register file of the deframer: holds the message length limit.
// Depends on alsd_pkg.
module alsd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [alsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [alsd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [alsd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [alsd_pkg::MAX_MSG_W-1:0]   max_message_bytes
);
  import alsd_pkg::*;

  logic [MAX_MSG_W-1:0] max_msg_r;
  logic                 reg_sel;
  logic                 wr_en;

  // Word index of the register; the low address bits are ignored.
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_MAX_MESSAGE_BYTES);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r <= MAX_MSG_RESET;
    end else if (wr_en) begin
      max_msg_r <= pwdata[MAX_MSG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(CFG_DATA_W-MAX_MSG_W){1'b0}}, max_msg_r};
    end
  end

  assign max_message_bytes = max_msg_r;

endmodule

// ===== sv/alsd_frame_core.sv =====
// Framing state machine: decodes header and length determinants of one octet
// and updates the message state when that octet moves on. Depends on alsd_pkg.
module alsd_frame_core #(
  parameter int HEADER_BYTES = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [7:0]                     byte_in,
  input  logic [alsd_pkg::MAX_MSG_W-1:0] max_message_bytes,
  output alsd_pkg::result_t              result
);
  import alsd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DET1   = 2'd1,
    PH_DET2   = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  localparam logic [1:0] HDR_LIMIT = 2'(HEADER_BYTES);
  localparam phase_t IDLE_PHASE = (HEADER_BYTES == 0) ? PH_DET1 : PH_HEADER;

  phase_t               phase_r, phase_nxt;
  logic [1:0]           hdr_cnt_r, hdr_cnt_nxt;
  logic [5:0]           len_hi_r, len_hi_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic                 more_r, more_nxt;
  logic [MAX_MSG_W-1:0] msg_cnt_r, msg_cnt_nxt;

  logic [MAX_MSG_W:0]   msg_inc;
  logic [1:0]           hdr_inc;
  logic [REM_W-1:0]     rem_dec;
  logic [5:0]           frag_mult;
  logic [13:0]          long_len;
  logic                 end_flag;
  framing_err_t         err;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    len_hi_nxt  = len_hi_r;
    rem_nxt     = rem_r;
    more_nxt    = more_r;
    end_flag    = 1'b0;
    err         = ERR_NONE;

    msg_inc   = {1'b0, msg_cnt_r} + 17'd1;
    // An incremented count above the 16-bit limit is always flagged, so the
    // stored count never needs the extra bit.
    msg_cnt_nxt = msg_inc[MAX_MSG_W-1:0];
    hdr_inc   = hdr_cnt_r + 2'd1;
    rem_dec   = (rem_r == '0) ? rem_r : rem_r - 17'd1;
    frag_mult = byte_in[5:0] & DET_VALUE_MASK[5:0];
    long_len  = {len_hi_r, byte_in};

    if (msg_inc > {1'b0, max_message_bytes}) begin
      err = ERR_OVERSIZE;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          hdr_cnt_nxt = hdr_inc;
          if (hdr_inc >= HDR_LIMIT) begin
            hdr_cnt_nxt = '0;
            phase_nxt   = PH_DET1;
          end
        end
        PH_DET1: begin
          if (!byte_in[7]) begin
            more_nxt = 1'b0;
            if (byte_in[6:0] == 7'd0) begin
              end_flag = 1'b1;
            end else begin
              rem_nxt   = REM_W'(byte_in[6:0]);
              phase_nxt = PH_BODY;
            end
          end else if ((byte_in & DET_CLASS_MASK) == DET_LONG_TAG) begin
            len_hi_nxt = frag_mult;
            phase_nxt  = PH_DET2;
          end else if (frag_mult == 6'd0 || frag_mult > MAX_FRAG_MULT) begin
            err = ERR_BAD_DET;
          end else begin
            rem_nxt   = REM_W'(frag_mult) << FRAG_SHIFT;
            more_nxt  = 1'b1;
            phase_nxt = PH_BODY;
          end
        end
        PH_DET2: begin
          more_nxt = 1'b0;
          if (long_len == 14'd0) begin
            end_flag = 1'b1;
          end else begin
            rem_nxt   = REM_W'(long_len);
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            if (more_r) begin
              phase_nxt = PH_DET1;
            end else begin
              end_flag = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = IDLE_PHASE;
        end
      endcase
    end

    // Completion or any error returns to the start of a new message.
    if (err != ERR_NONE || end_flag) begin
      phase_nxt   = IDLE_PHASE;
      hdr_cnt_nxt = '0;
      len_hi_nxt  = '0;
      rem_nxt     = '0;
      more_nxt    = 1'b0;
      msg_cnt_nxt = '0;
    end
  end

  assign result.byte_out      = byte_in;
  assign result.message_start = (msg_cnt_r == '0);
  assign result.message_end   = end_flag;
  assign result.framing_error = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= IDLE_PHASE;
      hdr_cnt_r <= '0;
      len_hi_r  <= '0;
      rem_r     <= '0;
      more_r    <= 1'b0;
      msg_cnt_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      len_hi_r  <= len_hi_nxt;
      rem_r     <= rem_nxt;
      more_r    <= more_nxt;
      msg_cnt_r <= msg_cnt_nxt;
    end
  end

  // The body phase is only ever entered with octets still to come.
  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> rem_r != '0)
    else $error("body phase with no octets remaining");

  // A finished or failed message leaves the octet count cleared.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (end_flag || err != ERR_NONE) |=> msg_cnt_r == '0 && phase_r == IDLE_PHASE)
    else $error("message state not cleared after end or error");

  // A message only starts from the idle phase with no header octets counted.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && msg_cnt_r == '0 |-> phase_r == IDLE_PHASE && hdr_cnt_r == '0 && !more_r)
    else $error("message start outside the idle phase");

endmodule

// ===== sv/aper_length_stream_deframer.sv =====
// APER length-stream deframer, top level.
//
// Octets of a byte stream enter on in_ch (valid/ready) and leave unchanged on
// out_ch, each with message_start, message_end and framing_error marks. A
// message is HEADER_BYTES header octets, then a length determinant (short,
// long, or fragment followed by a further determinant) and the body octets.
// A bad determinant, or a message longer than max_message_bytes, is flagged
// on the offending octet and the next octet begins a new message.
//
// The limit register sits at byte address 0 of the APB-style port; it must be
// written while the stream is quiet, which the block does not enforce. Reset
// restores a limit of 65535 and the header phase; no clearing pass is needed.
//
// An accepted octet waits in the input register, where the framing state is
// decoded, and its result then moves into the output register, from which the
// receiver takes it. One octet is accepted every cycle while the receiver does
// not stall; the single framing state update per octet sets that rate. When the
// receiver stalls, the output register holds its result and the input register
// takes one further octet before in_ch.ready falls.
module aper_length_stream_deframer #(
  parameter int HEADER_BYTES = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  alsd_in_if.sink                          in_ch,
  alsd_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [alsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [alsd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [alsd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import alsd_pkg::*;

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  result_t              core_res;
  logic                 s1_adv;
  logic                 out_free;
  logic [MAX_MSG_W-1:0] max_msg;

  alsd_cfg_regs u_cfg (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_message_bytes (max_msg)
  );

  alsd_frame_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (s1_adv),
    .byte_in           (s1_byte_r),
    .max_message_bytes (max_msg),
    .result            (core_res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_in;
    end
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_out      = out_res_r.byte_out;
  assign out_ch.message_start = out_res_r.message_start;
  assign out_ch.message_end   = out_res_r.message_end;
  assign out_ch.framing_error = out_res_r.framing_error;

  // A waiting octet in the input register is never dropped by a stall.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input register lost a transaction");

  // The input side only blocks when both registers are occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r)
    else $error("input blocked with free register space");

  // A new result only appears when an octet moved out of the input register.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a source transaction");

endmodule

// ===== test/tb_aper_length_stream_deframer.sv =====
// Self-checking testbench for the APER length-stream deframer: drives octet streams of
// framed messages, noise and broken determinants, and checks every marked octet.
// Depends on alsd_pkg, alsd_if.sv and aper_length_stream_deframer.sv.
`timescale 1ns / 100ps

module tb_aper_length_stream_deframer;
  import alsd_pkg::*;

  localparam int HDR_OCTETS = 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  // Zero-length short and long messages, fragment multipliers 0 and 5, one short body.
  localparam logic [7:0] DIRECTED_OCTETS [22] = '{
    8'h00, 8'hFF, 8'h00, 8'h00,
    8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00,
    8'hA5, 8'h5A, 8'h3C, 8'hC0,
    8'h12, 8'h34, 8'h56, 8'hC5,
    8'hC3, 8'h81, 8'h7E, 8'h01, 8'hEE
  };

  typedef enum logic [1:0] {FR_HEADER, FR_LEN_FIRST, FR_LEN_SECOND, FR_BODY} frame_phase_t;
  typedef enum {MK_SHORT, MK_LONG, MK_FRAG, MK_BAD_FRAG, MK_NOISE} msg_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  alsd_in_if in_ch ();
  alsd_out_if out_ch ();

  aper_length_stream_deframer #(.HEADER_BYTES(HDR_OCTETS)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Framing state as the block should hold it.
  logic [15:0] limit_reg = 16'hFFFF;
  frame_phase_t frame_phase = FR_HEADER;
  logic [1:0] hdr_seen = '0;
  logic [5:0] len_hi = '0;
  logic [19:0] body_left = '0;
  logic more_len = 1'b0;
  logic [16:0] msg_octets = '0;

  logic [7:0] octet_q[$];
  result_t marked_q[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int fail_count = 0;
  int octets_checked = 0;
  int quiet_cycles = 0;
  int msg_cnt;
  int msg_cap;
  logic hold_tgl = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void restart_frame();
    frame_phase = FR_HEADER;
    hdr_seen = '0;
    len_hi = '0;
    body_left = '0;
    more_len = 1'b0;
    msg_octets = '0;
  endfunction

  function automatic result_t mark_octet(input logic [7:0] b);
    result_t r;
    logic [13:0] len;
    logic [5:0] mult;
    logic done;
    framing_err_t err;
    r.byte_out = b;
    r.message_start = (msg_octets == 0);
    done = 1'b0;
    err = ERR_NONE;
    msg_octets = msg_octets + 17'd1;
    // The length limit is checked ahead of any determinant decoding.
    if (msg_octets > {1'b0, limit_reg}) begin
      err = ERR_OVERSIZE;
    end else begin
      case (frame_phase)
        FR_HEADER: begin
          hdr_seen = hdr_seen + 2'd1;
          if (hdr_seen >= HDR_OCTETS) begin
            hdr_seen = '0;
            frame_phase = FR_LEN_FIRST;
          end
        end
        FR_LEN_FIRST: begin
          if (!b[7]) begin
            more_len = 1'b0;
            if (b[6:0] == 0) begin
              done = 1'b1;
            end else begin
              body_left = 20'(b[6:0]);
              frame_phase = FR_BODY;
            end
          end else if ((b & DET_CLASS_MASK) == DET_LONG_TAG) begin
            len_hi = b[5:0];
            frame_phase = FR_LEN_SECOND;
          end else begin
            mult = b[5:0] & DET_VALUE_MASK[5:0];
            if (mult == 0 || mult > MAX_FRAG_MULT) begin
              err = ERR_BAD_DET;
            end else begin
              body_left = 20'(mult) << FRAG_SHIFT;
              more_len = 1'b1;
              frame_phase = FR_BODY;
            end
          end
        end
        FR_LEN_SECOND: begin
          len = {len_hi, b};
          more_len = 1'b0;
          if (len == 0) begin
            done = 1'b1;
          end else begin
            body_left = 20'(len);
            frame_phase = FR_BODY;
          end
        end
        default: begin
          if (body_left != 0) body_left = body_left - 20'd1;
          if (body_left == 0) begin
            if (more_len) frame_phase = FR_LEN_FIRST;
            else done = 1'b1;
          end
        end
      endcase
    end
    if (err != ERR_NONE || done) restart_frame();
    r.message_end = done;
    r.framing_error = err;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch at octet %0d: %s expected %0h got %0h", octets_checked, what,
               want_v, got_v);
  endtask

  task automatic check_octet();
    result_t want;
    if (marked_q.size() == 0) begin
      report_mismatch("unexpected transaction, byte_out", 0, out_ch.byte_out);
      return;
    end
    want = marked_q.pop_front();
    if (out_ch.byte_out !== want.byte_out)
      report_mismatch("byte_out", want.byte_out, out_ch.byte_out);
    if (out_ch.message_start !== want.message_start)
      report_mismatch("message_start", want.message_start, out_ch.message_start);
    if (out_ch.message_end !== want.message_end)
      report_mismatch("message_end", want.message_end, out_ch.message_end);
    if (out_ch.framing_error !== want.framing_error)
      report_mismatch("framing_error", want.framing_error, out_ch.framing_error);
    octets_checked++;
  endtask

  // Sender: an accepted octet is predicted at the edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) marked_q.push_back(mark_octet(in_ch.byte_in));
      if (!in_ch.valid || in_ch.ready) begin
        if (octet_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.byte_in <= octet_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_octet();
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Long receiver hold-off, started by a toggle from the stimulus process.
  always @(posedge clk) begin
    if (hold_tgl != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack <= hold_tgl;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (octet_q.size() != 0 || in_ch.valid || marked_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] value);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(REG_MAX_MESSAGE_BYTES) << 2;
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = value;
  endtask

  // Octets past the one that overruns the limit are dropped, so the stream
  // stays aligned with the block after the oversize error.
  task automatic put_octet(input logic [7:0] b);
    msg_cnt++;
    if (msg_cnt <= msg_cap) octet_q.push_back(b);
  endtask

  task automatic put_body(input int n);
    for (int i = 0; i < n && msg_cnt <= msg_cap; i++) put_octet(8'($urandom_range(255)));
  endtask

  task automatic put_det_body(input int len, input bit long_form);
    if (long_form) begin
      put_octet(DET_LONG_TAG | 8'(len >> 8));
      put_octet(8'(len));
    end else begin
      put_octet(8'(len) & 8'h7F);
    end
    put_body(len);
  endtask

  task automatic emit_message(input msg_kind_t kind, input int len, input int mult,
                              input bit long_tail);
    msg_cnt = 0;
    msg_cap = (kind == MK_NOISE) ? 1 << 20 : int'(limit_reg) + 1;
    if (kind != MK_NOISE)
      for (int i = 0; i < HDR_OCTETS; i++) put_octet(8'($urandom_range(255)));
    case (kind)
      MK_SHORT: put_det_body(len, 1'b0);
      MK_LONG: put_det_body(len, 1'b1);
      MK_FRAG: begin
        put_octet(DET_CLASS_MASK | 8'(mult));
        put_body(mult << FRAG_SHIFT);
        put_det_body(len, long_tail);
      end
      MK_BAD_FRAG: put_octet(DET_CLASS_MASK | 8'(mult));
      default: put_body(len);
    endcase
  endtask

  task automatic random_message(input bit allow_noise);
    int pick;
    int len;
    bit tight_limit;
    tight_limit = limit_reg < 1000;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(9))
        0: len = 0;
        1: len = 127;
        2: len = $urandom_range(126, 64);
        default: len = $urandom_range(20, 1);
      endcase
      emit_message(MK_SHORT, len, 0, 1'b0);
    end else if (pick < 75) begin
      if ($urandom_range(9) == 0) len = 0;
      else if (tight_limit) len = $urandom_range(16383);
      else len = $urandom_range(300, 1);
      emit_message(MK_LONG, len, 0, 1'b0);
    end else if (pick < 83) begin
      emit_message(MK_BAD_FRAG, 0, $urandom_range(1) ? 0 : $urandom_range(63, 5), 1'b0);
    end else if (pick < 90 && tight_limit) begin
      // Any fragment overruns a tight limit, so only its head is sent.
      emit_message(MK_FRAG, $urandom_range(20), $urandom_range(4, 1), $urandom_range(1));
    end else if (allow_noise && tight_limit) begin
      emit_message(MK_NOISE, $urandom_range(8, 1), 0, 1'b0);
    end else begin
      emit_message(MK_SHORT, $urandom_range(20, 1), 0, 1'b0);
    end
  endtask

  task automatic fill_random(input int target, input bit allow_noise);
    while (octet_q.size() < target) random_message(allow_noise);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 10;
    rcv_idle_pct = 50;
    set_limit(16'hFFFF);
    foreach (DIRECTED_OCTETS[i]) octet_q.push_back(DIRECTED_OCTETS[i]);
    fill_random(350, 1'b0);

    snd_idle_pct = 50;
    rcv_idle_pct = 10;
    set_limit(16'd4);
    fill_random(120, 1'b1);
    set_limit(16'($urandom_range(200, 5)));
    fill_random(300, 1'b1);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // A limit of the header length: the first octet after the header overruns.
    set_limit(16'd3);
    fill_random(60, 1'b1);

    set_limit(16'hFFFF);
    fill_random(150, 1'b0);
    @(posedge clk);
    hold_tgl <= ~hold_tgl;
    fill_random(octet_q.size() + 100, 1'b0);

    wait_idle();
    if (fail_count == 0 && marked_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/alsd_pkg.sv
sv/alsd_if.sv
sv/alsd_cfg_regs.sv
sv/alsd_frame_core.sv
sv/aper_length_stream_deframer.sv
test/tb_aper_length_stream_deframer.sv
